// ----- hdl/fhm_pkg.sv -----
`timescale 1ns / 1ps

package fhm_pkg;

  localparam int unsigned TableEntriesDefault = 1024;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [15:0] HttpMinLen    = 16'd7;

  // action carried in the input tuser
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // outcome codes
  localparam logic [2:0] OUT_NOT_IPV4 = 3'd0;
  localparam logic [2:0] OUT_NOT_TCP  = 3'd1;
  localparam logic [2:0] OUT_EMPTY    = 3'd2;
  localparam logic [2:0] OUT_TCP      = 3'd3;
  localparam logic [2:0] OUT_HTTP     = 3'd4;
  localparam logic [2:0] OUT_FULL     = 3'd5;
  localparam logic [2:0] OUT_READ     = 3'd6;

  // entry kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_TCP    = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_PUT    = 3'd3;
  localparam logic [2:0] KIND_POST   = 3'd4;
  localparam logic [2:0] KIND_DELETE = 3'd5;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [2:0]  kind;
    logic [63:0] bytes;
    logic [63:0] pkts;
  } entry_t;

  typedef struct packed {
    logic        drop;
    logic [2:0]  outcome;
    logic [15:0] len;
    logic [2:0]  method;
  } cls_t;

endpackage

// ----- hdl/fhm_table.sv -----
`timescale 1ns / 1ps

module fhm_table #(
  parameter int unsigned Depth = fhm_pkg::TableEntriesDefault,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  fhm_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [IdxW-1:0]  raddr_i,
  output fhm_pkg::entry_t  rdata_o
);

  fhm_pkg::entry_t mem [Depth];
  fhm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/fhm_classify.sv -----
`timescale 1ns / 1ps

module fhm_classify (
  input  logic [15:0]   ether_type_i,
  input  logic [7:0]    ip_protocol_i,
  input  logic [3:0]    ip_header_words_i,
  input  logic [15:0]   ip_total_length_i,
  input  logic [3:0]    tcp_header_words_i,
  input  logic [55:0]   payload_head_i,
  output fhm_pkg::cls_t cls_o
);

  logic signed [17:0] len;
  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [2:0] method;

  assign len = $signed(18'(ip_total_length_i)) - $signed(18'({ip_header_words_i, 2'b00}))
             - $signed(18'({tcp_header_words_i, 2'b00}));

  assign b0 = payload_head_i[55:48];
  assign b1 = payload_head_i[47:40];
  assign b2 = payload_head_i[39:32];
  assign b3 = payload_head_i[31:24];
  assign b4 = payload_head_i[23:16];
  assign b5 = payload_head_i[15:8];

  always_comb begin
    priority if (b0 == "G" && b1 == "E" && b2 == "T") begin
      method = fhm_pkg::KIND_GET;
    end else if (b0 == "P" && b1 == "O" && b2 == "S" && b3 == "T") begin
      method = fhm_pkg::KIND_POST;
    end else if (b0 == "P" && b1 == "U" && b2 == "T") begin
      method = fhm_pkg::KIND_PUT;
    end else if (b0 == "D" && b1 == "E" && b2 == "L" && b3 == "E" && b4 == "T"
                 && b5 == "E") begin
      method = fhm_pkg::KIND_DELETE;
    end else begin
      method = fhm_pkg::KIND_NONE;
    end
  end

  always_comb begin
    cls_o.drop    = 1'b1;
    cls_o.outcome = fhm_pkg::OUT_NOT_IPV4;
    cls_o.len     = len[15:0];
    cls_o.method  = fhm_pkg::KIND_NONE;
    priority if (ether_type_i != fhm_pkg::EtherTypeIpv4) begin
      cls_o.outcome = fhm_pkg::OUT_NOT_IPV4;
    end else if (ip_protocol_i != fhm_pkg::ProtoTcp) begin
      cls_o.outcome = fhm_pkg::OUT_NOT_TCP;
    end else if (len <= 18'sd0) begin
      cls_o.outcome = fhm_pkg::OUT_EMPTY;
    end else begin
      cls_o.drop    = 1'b0;
      cls_o.outcome = fhm_pkg::OUT_TCP;
      cls_o.method  = (len[15:0] >= fhm_pkg::HttpMinLen) ? method : fhm_pkg::KIND_NONE;
    end
  end

endmodule

// ----- hdl/tcp_http_flow_meter_core.sv -----
`timescale 1ns / 1ps
// flow: a dropped packet or a read of an unused slot goes from decode straight to emit, a read
//   passes through the table read states, a counted packet makes one table scan, two for HTTP
// throughput: one beat at a time; the linear scans through the flow table, which has one read
//   and one write port, read one entry per cycle
// reset: asynchronous active low, empties the table (entry count to zero) at once;
//   table contents are not cleared and never read before being written

module tcp_http_flow_meter_core #(
  parameter int unsigned TABLE_ENTRIES = fhm_pkg::TableEntriesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: ether_type, ip_protocol, ip_header_words, ip_total_length,
  // tcp_header_words, source_address, dest_address, source_port, dest_port,
  // payload_head, read_index, zero fill
  input  logic [215:0] s_axis_tdata_i,
  input  logic         s_axis_tuser_i,   // action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: slot, entry_valid, key_source_address, key_dest_address,
  // key_source_port, key_dest_port, byte_total, packet_total, zero fill
  output logic [239:0] m_axis_tdata_o,
  output logic [5:0]   m_axis_tuser_o    // outcome, api_kind
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned CmpW = (CntW > 10) ? CntW : 10;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_RD_ISSUE, S_RD_DATA, S_SCAN, S_UPDATE, S_EMIT
  } state_e;

  // captured beat
  logic        action_q;
  logic [15:0] ether_type_q;
  logic [7:0]  ip_protocol_q;
  logic [3:0]  ip_header_words_q;
  logic [15:0] ip_total_length_q;
  logic [3:0]  tcp_header_words_q;
  logic [31:0] src_addr_q, dst_addr_q;
  logic [15:0] sport_q, dport_q;
  logic [55:0] payload_head_q;
  logic [9:0]  read_index_q;

  state_e          state_q;
  logic [CntW-1:0] used_q;        // entries allocated so far
  logic [CntW-1:0] issue_q;       // next scan address
  logic            pend_q;        // a scan read is in flight
  logic [IdxW-1:0] pend_idx_q;
  logic [IdxW-1:0] slot_q;        // entry to write back
  logic            alloc_q;       // write back a fresh entry
  logic [2:0]      kind_q;        // kind looked up in this scan
  fhm_pkg::entry_t base_q;        // entry found by the scan

  // pending result
  logic [2:0]      res_outcome_q, res_kind_q;
  logic [9:0]      res_slot_q;
  logic            res_valid_q;
  fhm_pkg::entry_t res_entry_q;

  logic            out_valid_q;
  logic [239:0]    out_data_q;
  logic [5:0]      out_user_q;

  fhm_pkg::cls_t   cls;
  fhm_pkg::entry_t rdata, wdata;
  logic            we, re;
  logic [IdxW-1:0] raddr;
  logic            hit;
  logic            read_ok;

  fhm_classify u_classify (
    .ether_type_i      (ether_type_q),
    .ip_protocol_i     (ip_protocol_q),
    .ip_header_words_i (ip_header_words_q),
    .ip_total_length_i (ip_total_length_q),
    .tcp_header_words_i(tcp_header_words_q),
    .payload_head_i    (payload_head_q),
    .cls_o             (cls)
  );

  fhm_table #(.Depth(TABLE_ENTRIES)) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(slot_q),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign read_ok = CmpW'(read_index_q) < CmpW'(used_q);

  // key compare against the entry returned by the previous scan read
  assign hit = pend_q && rdata.src_addr == src_addr_q && rdata.dst_addr == dst_addr_q
            && rdata.sport == sport_q && rdata.dport == dport_q
            && rdata.kind == kind_q;

  always_comb begin
    re    = 1'b0;
    raddr = issue_q[IdxW-1:0];
    if (state_q == S_RD_ISSUE) begin
      re    = 1'b1;
      raddr = IdxW'(read_index_q);
    end else if (state_q == S_SCAN && issue_q != used_q && !hit) begin
      re = 1'b1;
    end
  end

  // read-modify-write of the counters, fresh entries start at zero
  assign we             = (state_q == S_UPDATE);
  assign wdata.src_addr = src_addr_q;
  assign wdata.dst_addr = dst_addr_q;
  assign wdata.sport    = sport_q;
  assign wdata.dport    = dport_q;
  assign wdata.kind     = kind_q;
  assign wdata.bytes    = (alloc_q ? 64'd0 : base_q.bytes) + 64'(cls.len);
  assign wdata.pkts     = (alloc_q ? 64'd0 : base_q.pkts) + 64'd1;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      action_q           <= s_axis_tuser_i;
      ether_type_q       <= s_axis_tdata_i[15:0];
      ip_protocol_q      <= s_axis_tdata_i[23:16];
      ip_header_words_q  <= s_axis_tdata_i[27:24];
      ip_total_length_q  <= s_axis_tdata_i[43:28];
      tcp_header_words_q <= s_axis_tdata_i[47:44];
      src_addr_q         <= s_axis_tdata_i[79:48];
      dst_addr_q         <= s_axis_tdata_i[111:80];
      sport_q            <= s_axis_tdata_i[127:112];
      dport_q            <= s_axis_tdata_i[143:128];
      payload_head_q     <= s_axis_tdata_i[199:144];
      read_index_q       <= s_axis_tdata_i[209:200];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // in the emit state a new beat takes the place of the one leaving
      if (m_axis_tvalid_o && m_axis_tready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_outcome_q <= (action_q == fhm_pkg::ACT_READ) ? fhm_pkg::OUT_READ
                                                           : cls.outcome;
          res_kind_q    <= fhm_pkg::KIND_NONE;
          res_slot_q    <= (action_q == fhm_pkg::ACT_READ) ? read_index_q : '0;
          res_valid_q   <= 1'b0;
          res_entry_q   <= '0;
          kind_q        <= fhm_pkg::KIND_TCP;
          issue_q       <= '0;
          pend_q        <= 1'b0;
          if (action_q == fhm_pkg::ACT_READ) begin
            state_q <= read_ok ? S_RD_ISSUE : S_EMIT;
          end else if (cls.drop) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_RD_ISSUE: begin
          state_q <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_kind_q  <= rdata.kind;
          res_valid_q <= 1'b1;
          res_entry_q <= rdata;
          state_q     <= S_EMIT;
        end
        S_SCAN: begin
          // no read is issued on a hit, so the pending flag drops by itself
          pend_q     <= re;
          pend_idx_q <= issue_q[IdxW-1:0];
          if (re) begin
            issue_q <= issue_q + 1'b1;
          end
          if (hit) begin
            base_q  <= rdata;
            slot_q  <= pend_idx_q;
            alloc_q <= 1'b0;
            state_q <= S_UPDATE;
          end else if (!pend_q && issue_q == used_q) begin
            // scan exhausted: allocate the next slot or report a full table
            if (used_q == CntW'(TABLE_ENTRIES)) begin
              res_outcome_q <= fhm_pkg::OUT_FULL;
              res_kind_q    <= kind_q;
              res_slot_q    <= '0;
              res_valid_q   <= 1'b0;
              res_entry_q   <= {src_addr_q, dst_addr_q, sport_q, dport_q,
                                fhm_pkg::KIND_NONE, 64'd0, 64'd0};
              state_q       <= S_EMIT;
            end else begin
              slot_q  <= used_q[IdxW-1:0];
              alloc_q <= 1'b1;
              used_q  <= used_q + 1'b1;
              state_q <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          res_outcome_q <= (kind_q == fhm_pkg::KIND_TCP) ? fhm_pkg::OUT_TCP
                                                         : fhm_pkg::OUT_HTTP;
          res_kind_q    <= kind_q;
          res_slot_q    <= 10'(slot_q);
          res_valid_q   <= 1'b1;
          res_entry_q   <= wdata;
          issue_q       <= '0;
          pend_q        <= 1'b0;
          if (kind_q == fhm_pkg::KIND_TCP && cls.method != fhm_pkg::KIND_NONE) begin
            // second lookup for the method entry of the same flow
            kind_q  <= cls.method;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!out_valid_q || m_axis_tready_i)) begin
      out_user_q <= {res_kind_q, res_outcome_q};
      out_data_q <= {5'd0, res_entry_q.pkts, res_entry_q.bytes, res_entry_q.dport,
                     res_entry_q.sport, res_entry_q.dst_addr, res_entry_q.src_addr,
                     res_valid_q, res_slot_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- hdl/fhm_checker.sv -----
`timescale 1ns / 1ps

module fhm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [239:0] m_axis_tdata_o,
  input logic [5:0]   m_axis_tuser_o
);

  // one item in flight: no back-to-back input beats
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // dropped packets report nothing but the outcome
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:0] == fhm_pkg::OUT_NOT_IPV4
      || m_axis_tuser_o[2:0] == fhm_pkg::OUT_NOT_TCP
      || m_axis_tuser_o[2:0] == fhm_pkg::OUT_EMPTY)
    |-> m_axis_tdata_o == '0 && m_axis_tuser_o[5:3] == fhm_pkg::KIND_NONE)
    else $error("dropped packet carries data");

  // counted packets report a valid entry with at least one packet
  a_counted_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:0] == fhm_pkg::OUT_TCP
      || m_axis_tuser_o[2:0] == fhm_pkg::OUT_HTTP)
    |-> m_axis_tdata_o[10] && m_axis_tdata_o[234:171] != 64'd0)
    else $error("counted packet without valid entry");

endmodule

bind tcp_http_flow_meter_core fhm_checker u_fhm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
